>>> sv/cdad_pkg.sv
// Package for the Gregorian date-plus-days core: transaction payload types,
// status codes, microcode format and the microcode program itself.
// No dependencies.
`default_nettype none

package cdad_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [15:0] day_count;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [1:0]  status;
  } out_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIV,
    OP_REM,
    OP_CHECK,
    OP_ADD,
    OP_WALK,
    OP_EMIT
  } uop_e;

  // Jump conditions: taken jumps go to the target, else to the next step
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOSTART,
    CND_INVALID,
    CND_ZERO,
    CND_NOFIT
  } cond_e;

  localparam int unsigned UPC_W     = 3;
  localparam int unsigned PROG_LEN  = 7;

  // Program step addresses
  localparam logic [UPC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [UPC_W-1:0] PC_DIV   = 3'd1;
  localparam logic [UPC_W-1:0] PC_REM   = 3'd2;
  localparam logic [UPC_W-1:0] PC_CHECK = 3'd3;
  localparam logic [UPC_W-1:0] PC_ADD   = 3'd4;
  localparam logic [UPC_W-1:0] PC_WALK  = 3'd5;
  localparam logic [UPC_W-1:0] PC_EMIT  = 3'd6;

  // Reciprocal of 100: (y * DIV100_MUL) >> DIV100_SHIFT is exact for y < 43699
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Microcode ROM
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_IDLE:  w = '{op: OP_NOP,   cond: CND_NOSTART, target: PC_IDLE};
      PC_DIV:   w = '{op: OP_DIV,   cond: CND_NEVER,   target: PC_IDLE};
      PC_REM:   w = '{op: OP_REM,   cond: CND_NEVER,   target: PC_IDLE};
      PC_CHECK: w = '{op: OP_CHECK, cond: CND_INVALID, target: PC_EMIT};
      PC_ADD:   w = '{op: OP_ADD,   cond: CND_ZERO,    target: PC_EMIT};
      PC_WALK:  w = '{op: OP_WALK,  cond: CND_NOFIT,   target: PC_WALK};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: PC_IDLE};
      default:  w = '{op: OP_NOP,   cond: CND_ALWAYS,  target: PC_IDLE};
    endcase
    return w;
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> sv/calendar_date_add_days_core.sv
// Gregorian date plus day count, run by a small microcode program.
// Depends on cdad_pkg (payload types, status codes, microcode ROM).
// Steps: divide, remainder, check, add, walk, emit. An invalid date goes
// from the check step straight to the emit step, a zero count from the add
// step; else the walk step runs, one month per cycle, until the day fits.
// One transaction at a time: busy stays high from accept through the result
// strobe, and the next accept can come in the cycle after the result. Reset
// clears the step counter only; the result strobe cannot be stalled.
`default_nettype none

module calendar_date_add_days_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire cdad_pkg::in_t  in_i,
  output logic              done_o,
  output cdad_pkg::out_t    res_o
);
  import cdad_pkg::*;

  // Sequencer state
  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;

  // Datapath registers
  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [16:0] day_q;
  logic [15:0] count_q;
  status_e     status_q;
  logic [7:0]  quot_q;   // year / 100
  logic [6:0]  rem_q;    // year % 100
  logic [1:0]  quot4_q;  // (year / 100) % 4

  logic        leap;
  logic [4:0]  len;
  logic        fits;
  logic        invalid;
  logic        cond_hit;
  logic        accept;
  logic [26:0] prod;

  assign uw     = ucode_rom(upc_q);
  assign accept = start && !busy;

  // Leap rule from the tracked remainders
  assign leap    = (year_q[1:0] == 2'd0) && ((rem_q != 7'd0) || (quot4_q == 2'd0));
  assign len     = month_len(month_q, leap);
  assign fits    = day_q <= 17'(len);
  assign invalid = (len == 5'd0) || (day_q == 17'd0) || !fits;
  assign prod    = 27'(year_q) * 27'(DIV100_MUL);

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      CND_NEVER:   cond_hit = 1'b0;
      CND_ALWAYS:  cond_hit = 1'b1;
      CND_NOSTART: cond_hit = !start;
      CND_INVALID: cond_hit = invalid;
      CND_ZERO:    cond_hit = (count_q == 16'd0);
      CND_NOFIT:   cond_hit = !fits;
      default:     cond_hit = 1'b1;
    endcase
  end

  // Next step
  always_comb begin
    upc_d = cond_hit ? uw.target : upc_q + 3'd1;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= PC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Handshake and result outputs
  always_comb begin
    busy                = (upc_q != PC_IDLE);
    done_o              = (uw.op == OP_EMIT);
    res_o.result_year   = year_q;
    res_o.result_month  = month_q;
    res_o.result_day    = day_q[4:0];
    res_o.status        = status_q;
  end

  // Datapath: act on the operation of the current step
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_NOP: begin
        if (accept) begin
          year_q   <= in_i.start_year;
          month_q  <= in_i.start_month;
          day_q    <= 17'(in_i.start_day);
          count_q  <= in_i.day_count;
          status_q <= ST_OK;
        end
      end
      OP_DIV: begin
        quot_q <= prod[DIV100_SHIFT +: 8];
      end
      OP_REM: begin
        rem_q   <= 7'(year_q - 14'(quot_q) * 14'd100);
        quot4_q <= quot_q[1:0];
      end
      OP_CHECK: begin
        if (invalid) begin
          status_q <= ST_INVALID;
        end
      end
      OP_ADD: begin
        day_q    <= day_q + 17'(count_q);
        status_q <= (count_q == 16'd0) ? ST_ZERO : ST_OK;
      end
      OP_WALK: begin
        // Drop one month and advance, wrapping into January of next year
        if (!fits) begin
          day_q <= day_q - 17'(len);
          if (month_q == 4'd12) begin
            month_q <= 4'd1;
            year_q  <= year_q + 14'd1;
            if (year_q == 14'h3FFF || rem_q == 7'd99) begin
              rem_q   <= 7'd0;
              quot4_q <= (year_q == 14'h3FFF) ? 2'd0 : quot4_q + 2'd1;
            end else begin
              rem_q <= rem_q + 7'd1;
            end
          end else begin
            month_q <= month_q + 4'd1;
          end
        end
      end
      OP_EMIT: begin
        // hold
      end
      default: begin
        // hold
      end
    endcase
  end

  // Checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("sequencer not idle after result");

  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_OK) |->
      (res_o.result_month != 4'd0 && res_o.result_month <= 4'd12 &&
       res_o.result_day != 5'd0 && day_q[16:5] == 12'd0))
    else $error("ok result carries an impossible date");

endmodule

`default_nettype wire
